// ===== hdl/iec_pkg.sv =====
// ----------------------------------------------------------------------------
// iec_pkg
// shared types and constants of the serial bus device engine
// ----------------------------------------------------------------------------
package iec_pkg;
	localparam int ATN_BYTES_DEF = 2;
	localparam int PH_W = 5;
	localparam logic [PH_W-1:0] PH_IDLE        = 5'd0;
	localparam logic [PH_W-1:0] PH_ATN_DELAY   = 5'd1;
	localparam logic [PH_W-1:0] PH_ATN_COLLECT = 5'd2;
	localparam logic [PH_W-1:0] PH_RD_READY    = 5'd3;
	localparam logic [PH_W-1:0] PH_RD_EOI_WAIT = 5'd4;
	localparam logic [PH_W-1:0] PH_RD_EOI_ACK  = 5'd5;
	localparam logic [PH_W-1:0] PH_RD_EOI_CLK  = 5'd6;
	localparam logic [PH_W-1:0] PH_RD_BIT_HIGH = 5'd7;
	localparam logic [PH_W-1:0] PH_RD_BIT_LOW  = 5'd8;
	localparam logic [PH_W-1:0] PH_LISTEN_WAIT = 5'd9;
	localparam logic [PH_W-1:0] PH_TURN_WAIT   = 5'd10;
	localparam logic [PH_W-1:0] PH_TURN_D1     = 5'd11;
	localparam logic [PH_W-1:0] PH_TURN_D2     = 5'd12;
	localparam logic [PH_W-1:0] PH_TALK_START  = 5'd13;
	localparam logic [PH_W-1:0] PH_TX_EOI_LOW  = 5'd14;
	localparam logic [PH_W-1:0] PH_TX_EOI_HIGH = 5'd15;
	localparam logic [PH_W-1:0] PH_TX_PRE      = 5'd16;
	localparam logic [PH_W-1:0] PH_TX_BIT1     = 5'd17;
	localparam logic [PH_W-1:0] PH_TX_BIT2     = 5'd18;
	localparam logic [PH_W-1:0] PH_TX_ACK      = 5'd19;
	localparam logic [PH_W-1:0] PH_TALK_END    = 5'd20;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_BYTE = 3'd1;
	localparam logic [2:0] EV_BYTE_EOI = 3'd2;
	localparam logic [2:0] EV_CMD = 3'd3;
	localparam logic [2:0] EV_SENT = 3'd4;
	localparam logic [2:0] EV_TIMEOUT = 3'd5;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_EOI_WIN = 2'd1;
	localparam logic [1:0] REG_BIT_DLY = 2'd2;
	localparam logic [1:0] REG_LIMIT   = 2'd3;

	localparam logic [3:0] CMD_LISTEN = 4'h2;
	localparam logic [3:0] CMD_TALK   = 4'h4;
	localparam logic [3:0] SEC_DATA   = 4'h6;
	localparam logic [3:0] SEC_OPEN   = 4'hF;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [15:0] eoi_window_ticks;
		logic [15:0] bit_delay_ticks;
		logic [7:0]  listen_limit;
	} cfg_t;

	typedef struct packed {
		logic       atn;
		logic       clk;
		logic       dat;
		logic       tx_last;
		logic [7:0] tx_byte;
	} tick_t;

	typedef struct packed {
		logic       pull_clk;
		logic       pull_data;
		logic       ready_res;
		logic [2:0] event_res;
		logic [7:0] rx_byte;
		logic [3:0] command_nibble;
		logic [3:0] device_number;
		logic [3:0] sec_addr;
		logic [3:0] secondary_nibble;
		logic       listen_req;
		logic       talk_req;
	} res_t;
endpackage

// ===== hdl/iec_cfg.sv =====
// ----------------------------------------------------------------------------
// iec_cfg
// configuration register file with plain write port
// ----------------------------------------------------------------------------
module iec_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output iec_pkg::cfg_t    cfg
);
	iec_pkg::cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= 16'd20000;
			cfg_q.eoi_window_ticks <= 16'd400;
			cfg_q.bit_delay_ticks <= 16'd160;
			cfg_q.listen_limit <= 8'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iec_pkg::REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				iec_pkg::REG_EOI_WIN: cfg_q.eoi_window_ticks <= cfg_data;
				iec_pkg::REG_BIT_DLY: cfg_q.bit_delay_ticks <= cfg_data;
				iec_pkg::REG_LIMIT:   cfg_q.listen_limit <= cfg_data[7:0];
			endcase
		end
	end
	assign cfg = cfg_q;
endmodule

// ===== hdl/iec_core.sv =====
// ----------------------------------------------------------------------------
// iec_core
// bus protocol state machine, one tick per beat
// ----------------------------------------------------------------------------
module iec_core #(
	parameter int ATN_BYTES = iec_pkg::ATN_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  iec_pkg::tick_t  tick,
	input  iec_pkg::cfg_t   cfg,
	output iec_pkg::res_t   res
);
	localparam int CW = $clog2(ATN_BYTES + 1);
	localparam int AW = (ATN_BYTES > 1) ? $clog2(ATN_BYTES) : 1;

	logic [iec_pkg::PH_W-1:0] phase_q, phase_d;
	logic [15:0] tick_q, tick_d, tinc;
	logic [7:0]  shift_q, shift_d;
	logic [3:0]  bits_q, bits_d, binc;
	logic [7:0]  atn_q [ATN_BYTES], atn_d [ATN_BYTES];
	logic [CW-1:0] acnt_q, acnt_d;
	logic [7:0]  lcnt_q, lcnt_d;
	logic        eoi_q, eoi_d, dclk_q, dclk_d, ddat_q, ddat_d, rdl_q, rdl_d;
	logic [2:0]  ev;
	logic [7:0]  rx;
	logic        wt_hit, wt_to, dly_done;
	logic        wline, wwant, rd_end, rd_ok;
	logic [7:0]  sec, lcnt_n;
	logic        want_l, want_t;

	assign tinc = tick_q + 16'd1;
	assign binc = bits_q + 4'd1;
	assign sec = (ATN_BYTES > 1) ? atn_q[ATN_BYTES > 1 ? 1 : 0] : 8'd0;
	assign want_l = (sec[7:4] == iec_pkg::SEC_OPEN || sec[7:4] == iec_pkg::SEC_DATA)
		&& atn_q[0][7:4] == iec_pkg::CMD_LISTEN;
	assign want_t = (sec[7:4] == iec_pkg::SEC_OPEN || sec[7:4] == iec_pkg::SEC_DATA)
		&& atn_q[0][7:4] == iec_pkg::CMD_TALK;
	assign wt_hit = (wline == wwant);
	assign wt_to = !wt_hit && (tinc >= cfg.timeout_ticks);
	assign dly_done = tinc >= cfg.bit_delay_ticks;
	assign lcnt_n = (lcnt_q != 8'hFF) ? lcnt_q + 8'd1 : lcnt_q;

	always_comb begin
		wline = tick.clk;
		wwant = 1'b1;
		unique case (phase_q)
			iec_pkg::PH_RD_READY, iec_pkg::PH_TX_EOI_HIGH: begin
				wline = tick.dat;
			end
			iec_pkg::PH_TX_EOI_LOW, iec_pkg::PH_TX_ACK: begin
				wline = tick.dat;
				wwant = 1'b0;
			end
			iec_pkg::PH_RD_EOI_CLK, iec_pkg::PH_RD_BIT_LOW: begin
				wwant = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		tick_d = wt_hit ? 16'd0 : (wt_to ? 16'd0 : tinc);
		shift_d = shift_q;
		bits_d = bits_q;
		atn_d = atn_q;
		acnt_d = acnt_q;
		lcnt_d = lcnt_q;
		eoi_d = eoi_q;
		dclk_d = dclk_q;
		ddat_d = ddat_q;
		rdl_d = rdl_q;
		ev = iec_pkg::EV_NONE;
		rx = 8'd0;
		rd_end = 1'b0;
		rd_ok = 1'b0;
		unique case (phase_q)
			iec_pkg::PH_IDLE: begin
				tick_d = tick_q;
				ddat_d = 1'b0;
				if (!tick.atn) begin
					tick_d = 16'd0;
					phase_d = iec_pkg::PH_ATN_DELAY;
				end
			end
			iec_pkg::PH_ATN_DELAY: begin
				tick_d = dly_done ? 16'd0 : tinc;
				if (dly_done) begin
					dclk_d = 1'b0;
					ddat_d = 1'b1;
					acnt_d = '0;
					for (int i = 0; i < ATN_BYTES; i++) atn_d[i] = 8'd0;
					phase_d = iec_pkg::PH_ATN_COLLECT;
				end
			end
			iec_pkg::PH_ATN_COLLECT: begin
				tick_d = tick_q;
				if (tick.atn) begin
					ev = iec_pkg::EV_CMD;
					tick_d = 16'd0;
					if (want_t) phase_d = iec_pkg::PH_TURN_WAIT;
					else if (want_l) begin
						lcnt_d = 8'd0;
						phase_d = iec_pkg::PH_LISTEN_WAIT;
					end else begin
						phase_d = iec_pkg::PH_IDLE;
						ddat_d = 1'b0;
						dclk_d = 1'b0;
					end
				end else if (tick.clk && acnt_q < CW'(ATN_BYTES)) begin
					rdl_d = 1'b0;
					ddat_d = 1'b0;
					tick_d = 16'd0;
					phase_d = iec_pkg::PH_RD_READY;
				end
			end
			iec_pkg::PH_RD_READY: begin
				if (wt_hit) phase_d = iec_pkg::PH_RD_EOI_WAIT;
				else if (wt_to) rd_end = 1'b1;
			end
			iec_pkg::PH_RD_EOI_WAIT: begin
				if (!tick.clk) begin
					eoi_d = 1'b0;
					tick_d = 16'd0;
					shift_d = 8'd0;
					bits_d = 4'd0;
					phase_d = iec_pkg::PH_RD_BIT_HIGH;
				end else if (tinc >= cfg.eoi_window_ticks) begin
					eoi_d = 1'b1;
					ddat_d = 1'b1;
					tick_d = 16'd0;
					phase_d = iec_pkg::PH_RD_EOI_ACK;
				end else tick_d = tinc;
			end
			iec_pkg::PH_RD_EOI_ACK: begin
				tick_d = dly_done ? 16'd0 : tinc;
				if (dly_done) begin
					ddat_d = 1'b0;
					phase_d = iec_pkg::PH_RD_EOI_CLK;
				end
			end
			iec_pkg::PH_RD_EOI_CLK: begin
				if (wt_hit) begin
					shift_d = 8'd0;
					bits_d = 4'd0;
					phase_d = iec_pkg::PH_RD_BIT_HIGH;
				end else if (wt_to) rd_end = 1'b1;
			end
			iec_pkg::PH_RD_BIT_HIGH: begin
				if (wt_hit) begin
					shift_d = {tick.dat, shift_q[7:1]};
					phase_d = iec_pkg::PH_RD_BIT_LOW;
				end else if (wt_to) rd_end = 1'b1;
			end
			iec_pkg::PH_RD_BIT_LOW: begin
				if (wt_hit) begin
					bits_d = binc;
					if (binc >= 4'd8) begin
						ddat_d = 1'b1;
						rd_end = 1'b1;
						rd_ok = 1'b1;
					end else phase_d = iec_pkg::PH_RD_BIT_HIGH;
				end else if (wt_to) rd_end = 1'b1;
			end
			iec_pkg::PH_LISTEN_WAIT: begin
				if (wt_hit) begin
					rdl_d = 1'b1;
					ddat_d = 1'b0;
					phase_d = iec_pkg::PH_RD_READY;
				end else if (wt_to) begin
					ev = iec_pkg::EV_TIMEOUT;
					phase_d = iec_pkg::PH_IDLE;
					ddat_d = 1'b0;
					dclk_d = 1'b0;
				end
			end
			iec_pkg::PH_TURN_WAIT: begin
				if (wt_hit || wt_to) begin
					ddat_d = 1'b0;
					phase_d = iec_pkg::PH_TURN_D1;
				end
			end
			iec_pkg::PH_TURN_D1: begin
				tick_d = dly_done ? 16'd0 : tinc;
				if (dly_done) begin
					dclk_d = 1'b1;
					phase_d = iec_pkg::PH_TURN_D2;
				end
			end
			iec_pkg::PH_TURN_D2: begin
				tick_d = dly_done ? 16'd0 : tinc;
				if (dly_done) begin
					dclk_d = 1'b0;
					phase_d = iec_pkg::PH_TALK_START;
				end
			end
			iec_pkg::PH_TALK_START: begin
				dclk_d = 1'b0;
				if (wt_hit) begin
					shift_d = tick.tx_byte;
					eoi_d = tick.tx_last;
					phase_d = tick.tx_last ? iec_pkg::PH_TX_EOI_LOW : iec_pkg::PH_TX_PRE;
				end else if (wt_to) begin
					ev = iec_pkg::EV_TIMEOUT;
					phase_d = iec_pkg::PH_TALK_END;
				end
			end
			iec_pkg::PH_TX_EOI_LOW, iec_pkg::PH_TX_EOI_HIGH: begin
				if (wt_hit) begin
					phase_d = (phase_q == iec_pkg::PH_TX_EOI_LOW) ?
						iec_pkg::PH_TX_EOI_HIGH : iec_pkg::PH_TX_PRE;
				end else if (wt_to) begin
					ev = iec_pkg::EV_TIMEOUT;
					phase_d = iec_pkg::PH_TALK_END;
				end
			end
			iec_pkg::PH_TX_PRE: begin
				tick_d = dly_done ? 16'd0 : tinc;
				if (dly_done) begin
					dclk_d = 1'b1;
					bits_d = 4'd0;
					phase_d = iec_pkg::PH_TX_BIT1;
				end
			end
			iec_pkg::PH_TX_BIT1: begin
				tick_d = dly_done ? 16'd0 : tinc;
				if (dly_done) begin
					ddat_d = !shift_q[0];
					dclk_d = 1'b0;
					phase_d = iec_pkg::PH_TX_BIT2;
				end
			end
			iec_pkg::PH_TX_BIT2: begin
				tick_d = dly_done ? 16'd0 : tinc;
				if (dly_done) begin
					dclk_d = 1'b1;
					ddat_d = 1'b0;
					shift_d = {1'b0, shift_q[7:1]};
					bits_d = binc;
					phase_d = (binc >= 4'd8) ? iec_pkg::PH_TX_ACK : iec_pkg::PH_TX_BIT1;
				end
			end
			iec_pkg::PH_TX_ACK: begin
				if (wt_hit) begin
					ev = iec_pkg::EV_SENT;
					phase_d = eoi_q ? iec_pkg::PH_TALK_END : iec_pkg::PH_TALK_START;
				end else if (wt_to) begin
					ev = iec_pkg::EV_TIMEOUT;
					phase_d = iec_pkg::PH_TALK_END;
				end
			end
			iec_pkg::PH_TALK_END: begin
				tick_d = dly_done ? 16'd0 : tinc;
				if (dly_done) begin
					phase_d = iec_pkg::PH_IDLE;
					ddat_d = 1'b0;
					dclk_d = 1'b0;
				end
			end
			default: begin
				phase_d = iec_pkg::PH_IDLE;
				ddat_d = 1'b0;
				dclk_d = 1'b0;
				tick_d = 16'd0;
			end
		endcase

		if (rd_end) begin
			tick_d = 16'd0;
			if (!rdl_q) begin
				if (!rd_ok) ev = iec_pkg::EV_TIMEOUT;
				if (acnt_q < CW'(ATN_BYTES)) begin
					atn_d[AW'(acnt_q)] = rd_ok ? shift_q : 8'd0;
					acnt_d = acnt_q + CW'(1);
				end
				phase_d = iec_pkg::PH_ATN_COLLECT;
			end else if (!rd_ok) begin
				ev = iec_pkg::EV_TIMEOUT;
				phase_d = iec_pkg::PH_IDLE;
				ddat_d = 1'b0;
				dclk_d = 1'b0;
			end else begin
				lcnt_d = lcnt_n;
				ev = eoi_q ? iec_pkg::EV_BYTE_EOI : iec_pkg::EV_BYTE;
				rx = shift_q;
				if (eoi_q || lcnt_n >= cfg.listen_limit) begin
					phase_d = iec_pkg::PH_IDLE;
					ddat_d = 1'b0;
					dclk_d = 1'b0;
				end else phase_d = iec_pkg::PH_LISTEN_WAIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= iec_pkg::PH_IDLE;
			tick_q <= '0;
			shift_q <= '0;
			bits_q <= '0;
			for (int i = 0; i < ATN_BYTES; i++) atn_q[i] <= '0;
			acnt_q <= '0;
			lcnt_q <= '0;
			eoi_q <= 1'b0;
			dclk_q <= 1'b0;
			ddat_q <= 1'b0;
			rdl_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q <= tick_d;
			shift_q <= shift_d;
			bits_q <= bits_d;
			atn_q <= atn_d;
			acnt_q <= acnt_d;
			lcnt_q <= lcnt_d;
			eoi_q <= eoi_d;
			dclk_q <= dclk_d;
			ddat_q <= ddat_d;
			rdl_q <= rdl_d;
		end
	end

	logic [7:0] sec_d;
	assign sec_d = (ATN_BYTES > 1) ? atn_d[ATN_BYTES > 1 ? 1 : 0] : 8'd0;

	always_comb begin
		res.pull_clk = dclk_d;
		res.pull_data = ddat_d;
		res.ready_res = (phase_d == iec_pkg::PH_IDLE);
		res.event_res = ev;
		res.rx_byte = rx;
		res.command_nibble = atn_d[0][7:4];
		res.device_number = atn_d[0][3:0];
		res.sec_addr = sec_d[3:0];
		res.secondary_nibble = sec_d[7:4];
		res.listen_req = (sec_d[7:4] == iec_pkg::SEC_OPEN || sec_d[7:4] == iec_pkg::SEC_DATA)
			&& atn_d[0][7:4] == iec_pkg::CMD_LISTEN;
		res.talk_req = (sec_d[7:4] == iec_pkg::SEC_OPEN || sec_d[7:4] == iec_pkg::SEC_DATA)
			&& atn_d[0][7:4] == iec_pkg::CMD_TALK;
	end

`ifndef ASSERT_OFF
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		acnt_q <= CW'(ATN_BYTES)) else $error("atn count overflow");
	a_idle_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q != iec_pkg::PH_IDLE && phase_d == iec_pkg::PH_IDLE)
		|=> !dclk_q) else $error("clk held at idle");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= iec_pkg::PH_TALK_END) else $error("bad phase");
	a_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(ev != iec_pkg::EV_BYTE && ev != iec_pkg::EV_BYTE_EOI) |-> rx == 8'd0)
		else $error("rx without byte");
`endif
endmodule

// ===== hdl/iec_serial_bus_device_engine.sv =====
// ----------------------------------------------------------------------------
// iec_serial_bus_device_engine
// device side of the serial bus, one tick per input beat
// ----------------------------------------------------------------------------
// each input beat is one 0.5 us tick: s_tdata {data,clk,atn} levels in bits
// 2:0, tx_byte in 10:3, s_tuser carries tx_last (byte to send while talking).
// each accepted beat yields exactly one output beat with the open-drain pulls,
// ready flag, event code, received byte and the decoded command fields.
// throughput: one beat per cycle unless stalled; the protocol state update
// is a single pass over the state register; the output beat is registered.
// s_tready stays high while the output register is empty or being taken, so a
// stalled receiver holds the output beat and stops input after one beat.
// reset: all phases idle, lines released, configuration at defaults.
// configuration writes (cfg_we, cfg_index, cfg_data) take effect next cycle.
// ----------------------------------------------------------------------------
module iec_serial_bus_device_engine #(
	parameter int ATN_BYTES = iec_pkg::ATN_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // atn_level, clk_level, data_level, tx_byte, zero pad
	input  logic        s_tuser,  // tx_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // pull_clk, pull_data, ready_res, event_res, rx_byte,
	                              // command_nibble, device_number, sec_addr,
	                              // secondary_nibble, listen_req, talk_req
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	iec_pkg::cfg_t  cfg;
	iec_pkg::tick_t tick;
	iec_pkg::res_t  res, res_q;
	logic           step, vld_q;

	assign s_tready = !vld_q || m_tready;
	assign step = s_tvalid && s_tready;
	assign tick.atn = s_tdata[0];
	assign tick.clk = s_tdata[1];
	assign tick.dat = s_tdata[2];
	assign tick.tx_byte = s_tdata[10:3];
	assign tick.tx_last = s_tuser;

	iec_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg)
	);

	iec_core #(.ATN_BYTES(ATN_BYTES)) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .tick(tick), .cfg(cfg), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (s_tready) begin
			vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata = {res_q.talk_req, res_q.listen_req, res_q.secondary_nibble,
		res_q.sec_addr, res_q.device_number, res_q.command_nibble,
		res_q.rx_byte, res_q.event_res, res_q.ready_res, res_q.pull_data,
		res_q.pull_clk};
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the serial bus device engine tick by tick against a local predictor
// ----------------------------------------------------------------------------
// a bus host emulator picks the atn, clk and data levels of every tick from
// the predicted device state: command bytes under atn, listen bytes with and
// without eoi, talk turnaround and sent bytes. Some ticks carry noise and some
// withhold a wanted level, so waits also run into timeouts. Every output beat
// is compared field by field with the predicted one. Both stream sides idle
// at random, and the configuration is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import iec_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_TIMEOUT;
	logic [15:0] cfg_data = '0;

	iec_serial_bus_device_engine dut (.*);

	initial forever #6 clk = ~clk;

	// predicted device state
	logic [15:0] c_timeout, c_eoi_win, c_bit_dly;
	logic [7:0]  c_limit;
	logic [4:0]  m_ph;
	logic [15:0] m_tcnt;
	logic [7:0]  m_shift;
	logic [3:0]  m_bits;
	logic [7:0]  m_atn [2];
	logic [1:0]  m_atn_cnt;
	logic [7:0]  m_lcnt;
	logic        m_eoi, m_pclk, m_pdat, m_rd_listen;
	logic [2:0]  m_ev;
	logic [7:0]  m_rx;

	res_t results_due[$];
	int   errors = 0;
	int   idle_cycles = 0;
	int   stall_left = 0;
	bit   no_gaps = 0;

	// bus host state
	logic [7:0] h_byte;
	logic       h_eoi;
	int         h_target;

	function automatic int wait_line(logic line, logic want);
		if (line == want) begin
			m_tcnt = 0;
			return 1;
		end
		m_tcnt++;
		if (m_tcnt >= c_timeout) begin
			m_tcnt = 0;
			return 2;
		end
		return 0;
	endfunction

	function automatic bit delay_over();
		m_tcnt++;
		if (m_tcnt >= c_bit_dly) begin
			m_tcnt = 0;
			return 1;
		end
		return 0;
	endfunction

	function automatic void enter_idle();
		m_ph = PH_IDLE;
		m_pdat = 0;
		m_pclk = 0;
		m_tcnt = 0;
	endfunction

	function automatic void begin_read(logic for_listen);
		m_rd_listen = for_listen;
		m_pdat = 0;
		m_tcnt = 0;
		m_ph = PH_RD_READY;
	endfunction

	function automatic void finish_read(bit ok);
		logic [7:0] b;
		b = ok ? m_shift : 8'h00;
		m_tcnt = 0;
		if (!m_rd_listen) begin
			if (!ok) m_ev = EV_TIMEOUT;
			if (m_atn_cnt < 2) begin
				m_atn[m_atn_cnt[0]] = b;
				m_atn_cnt++;
			end
			m_ph = PH_ATN_COLLECT;
			return;
		end
		if (!ok) begin
			m_ev = EV_TIMEOUT;
			enter_idle();
			return;
		end
		if (m_lcnt < 8'd255) m_lcnt++;
		m_ev = m_eoi ? EV_BYTE_EOI : EV_BYTE;
		m_rx = b;
		if (m_eoi || m_lcnt >= c_limit) enter_idle();
		else m_ph = PH_LISTEN_WAIT;
	endfunction

	function automatic bit is_open_or_data();
		return m_atn[1][7:4] == SEC_OPEN || m_atn[1][7:4] == SEC_DATA;
	endfunction

	function automatic bit wants_listen();
		return is_open_or_data() && m_atn[0][7:4] == CMD_LISTEN;
	endfunction

	function automatic bit wants_talk();
		return is_open_or_data() && m_atn[0][7:4] == CMD_TALK;
	endfunction

	function automatic void predict_tick(tick_t t, output res_t r);
		int w;
		m_ev = EV_NONE;
		m_rx = 0;
		case (m_ph)
			PH_IDLE: begin
				m_pdat = 0;
				if (!t.atn) begin
					m_tcnt = 0;
					m_ph = PH_ATN_DELAY;
				end
			end
			PH_ATN_DELAY: if (delay_over()) begin
				m_pclk = 0;
				m_pdat = 1;
				m_atn_cnt = 0;
				m_atn[0] = 0;
				m_atn[1] = 0;
				m_ph = PH_ATN_COLLECT;
			end
			PH_ATN_COLLECT: begin
				if (t.atn) begin
					m_ev = EV_CMD;
					m_tcnt = 0;
					if (wants_talk()) m_ph = PH_TURN_WAIT;
					else if (wants_listen()) begin
						m_lcnt = 0;
						m_ph = PH_LISTEN_WAIT;
					end else enter_idle();
				end else if (t.clk && m_atn_cnt < 2) begin
					begin_read(0);
				end
			end
			PH_RD_READY: begin
				w = wait_line(t.dat, 1);
				if (w == 1) m_ph = PH_RD_EOI_WAIT;
				else if (w == 2) finish_read(0);
			end
			PH_RD_EOI_WAIT: begin
				if (!t.clk) begin
					m_eoi = 0;
					m_tcnt = 0;
					m_shift = 0;
					m_bits = 0;
					m_ph = PH_RD_BIT_HIGH;
				end else begin
					m_tcnt++;
					if (m_tcnt >= c_eoi_win) begin
						m_eoi = 1;
						m_pdat = 1;
						m_tcnt = 0;
						m_ph = PH_RD_EOI_ACK;
					end
				end
			end
			PH_RD_EOI_ACK: if (delay_over()) begin
				m_pdat = 0;
				m_ph = PH_RD_EOI_CLK;
			end
			PH_RD_EOI_CLK: begin
				w = wait_line(t.clk, 0);
				if (w == 1) begin
					m_shift = 0;
					m_bits = 0;
					m_ph = PH_RD_BIT_HIGH;
				end else if (w == 2) finish_read(0);
			end
			PH_RD_BIT_HIGH: begin
				w = wait_line(t.clk, 1);
				if (w == 1) begin
					m_shift = {t.dat, m_shift[7:1]};
					m_ph = PH_RD_BIT_LOW;
				end else if (w == 2) finish_read(0);
			end
			PH_RD_BIT_LOW: begin
				w = wait_line(t.clk, 0);
				if (w == 1) begin
					m_bits++;
					if (m_bits >= 8) begin
						m_pdat = 1;
						finish_read(1);
					end else m_ph = PH_RD_BIT_HIGH;
				end else if (w == 2) finish_read(0);
			end
			PH_LISTEN_WAIT: begin
				w = wait_line(t.clk, 1);
				if (w == 1) begin_read(1);
				else if (w == 2) begin
					m_ev = EV_TIMEOUT;
					enter_idle();
				end
			end
			PH_TURN_WAIT: if (wait_line(t.clk, 1) != 0) begin
				m_pdat = 0;
				m_ph = PH_TURN_D1;
			end
			PH_TURN_D1: if (delay_over()) begin
				m_pclk = 1;
				m_ph = PH_TURN_D2;
			end
			PH_TURN_D2: if (delay_over()) begin
				m_pclk = 0;
				m_ph = PH_TALK_START;
			end
			PH_TALK_START: begin
				m_pclk = 0;
				w = wait_line(t.clk, 1);
				if (w == 1) begin
					m_shift = t.tx_byte;
					m_eoi = t.tx_last;
					m_ph = m_eoi ? PH_TX_EOI_LOW : PH_TX_PRE;
				end else if (w == 2) begin
					m_ev = EV_TIMEOUT;
					m_ph = PH_TALK_END;
				end
			end
			PH_TX_EOI_LOW: begin
				w = wait_line(t.dat, 0);
				if (w == 1) m_ph = PH_TX_EOI_HIGH;
				else if (w == 2) begin
					m_ev = EV_TIMEOUT;
					m_ph = PH_TALK_END;
				end
			end
			PH_TX_EOI_HIGH: begin
				w = wait_line(t.dat, 1);
				if (w == 1) m_ph = PH_TX_PRE;
				else if (w == 2) begin
					m_ev = EV_TIMEOUT;
					m_ph = PH_TALK_END;
				end
			end
			PH_TX_PRE: if (delay_over()) begin
				m_pclk = 1;
				m_bits = 0;
				m_ph = PH_TX_BIT1;
			end
			PH_TX_BIT1: if (delay_over()) begin
				m_pdat = ~m_shift[0];
				m_pclk = 0;
				m_ph = PH_TX_BIT2;
			end
			PH_TX_BIT2: if (delay_over()) begin
				m_pclk = 1;
				m_pdat = 0;
				m_shift = m_shift >> 1;
				m_bits++;
				m_ph = (m_bits >= 8) ? PH_TX_ACK : PH_TX_BIT1;
			end
			PH_TX_ACK: begin
				w = wait_line(t.dat, 0);
				if (w == 1) begin
					m_ev = EV_SENT;
					m_ph = m_eoi ? PH_TALK_END : PH_TALK_START;
				end else if (w == 2) begin
					m_ev = EV_TIMEOUT;
					m_ph = PH_TALK_END;
				end
			end
			PH_TALK_END: if (delay_over()) enter_idle();
			default: enter_idle();
		endcase
		r.pull_clk = m_pclk;
		r.pull_data = m_pdat;
		r.ready_res = (m_ph == PH_IDLE);
		r.event_res = m_ev;
		r.rx_byte = m_rx;
		r.command_nibble = m_atn[0][7:4];
		r.device_number = m_atn[0][3:0];
		r.sec_addr = m_atn[1][3:0];
		r.secondary_nibble = m_atn[1][7:4];
		r.listen_req = wants_listen();
		r.talk_req = wants_talk();
	endfunction

	function automatic logic [7:0] pick_atn_byte(int n);
		int s;
		s = $urandom_range(0, 5);
		if (n == 0) case (s)
			0, 1, 2: return {CMD_LISTEN, 4'($urandom)};
			3, 4: return {CMD_TALK, 4'($urandom)};
			default: return 8'($urandom);
		endcase
		case (s)
			0, 1, 2: return {SEC_DATA, 4'($urandom)};
			3, 4: return {SEC_OPEN, 4'($urandom)};
			default: return 8'($urandom);
		endcase
	endfunction

	// bus host: line levels a cooperating controller would present next
	function automatic tick_t host_tick(int noise_pct);
		tick_t t;
		bit hold;
		t.atn = 1'($urandom_range(0, 1));
		t.clk = 1'($urandom_range(0, 1));
		t.dat = 1'($urandom_range(0, 1));
		t.tx_byte = 8'($urandom);
		t.tx_last = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 99) < noise_pct) return t;
		hold = ($urandom_range(0, 9) == 0);
		case (m_ph)
			PH_IDLE: begin
				t.atn = ($urandom_range(0, 5) != 0);
				if (!t.atn) h_target = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 2;
			end
			PH_ATN_DELAY: t.atn = 0;
			PH_ATN_COLLECT: begin
				t.atn = (m_atn_cnt >= h_target) && !hold;
				t.clk = 1;
			end
			PH_RD_READY: begin
				t.atn = m_rd_listen;
				t.dat = !hold;
				if (m_rd_listen) begin
					h_byte = 8'($urandom);
					h_eoi = ($urandom_range(0, 4) == 0);
				end else h_byte = pick_atn_byte(m_atn_cnt);
			end
			PH_RD_EOI_WAIT: begin
				t.atn = m_rd_listen;
				t.clk = h_eoi || hold;
			end
			PH_RD_EOI_ACK, PH_RD_EOI_CLK: begin
				t.atn = m_rd_listen;
				t.clk = hold;
			end
			PH_RD_BIT_HIGH: begin
				t.atn = m_rd_listen;
				t.clk = !hold;
				t.dat = h_byte[m_bits[2:0]];
			end
			PH_RD_BIT_LOW: begin
				t.atn = m_rd_listen;
				t.clk = hold;
			end
			PH_LISTEN_WAIT, PH_TURN_WAIT, PH_TALK_START: t.clk = !hold;
			PH_TX_EOI_LOW, PH_TX_ACK: t.dat = hold;
			PH_TX_EOI_HIGH: t.dat = !hold;
			default: ;
		endcase
		return t;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic send_tick(tick_t t);
		res_t r;
		int gap;
		gap = 0;
		if (!no_gaps) begin
			if ($urandom_range(0, 29) == 0) gap = $urandom_range(10, 50);
			else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'd0, t.tx_byte, t.dat, t.clk, t.atn};
		s_tuser <= t.tx_last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_tick(t, r);
		results_due.push_back(r);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_TIMEOUT: c_timeout = val;
			REG_EOI_WIN: c_eoi_win = val;
			REG_BIT_DLY: c_bit_dly = val;
			default: c_limit = val[7:0];
		endcase
	endtask

	task automatic configure(logic [15:0] tmo, logic [15:0] win, logic [15:0] dly,
			logic [7:0] lim);
		drain();
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_EOI_WIN, win);
		write_reg(REG_BIT_DLY, dly);
		write_reg(REG_LIMIT, {8'd0, lim});
		cfg_we <= 0;
	endtask

	task automatic run_host(int n, int noise_pct);
		repeat (n) send_tick(host_tick(noise_pct));
	endtask

	task automatic test_field_extremes();
		tick_t t;
		for (int i = 0; i < 20; i++) begin
			t.atn = i[0];
			t.clk = i[1];
			t.dat = i[2];
			t.tx_byte = i[0] ? 8'hFF : 8'h00;
			t.tx_last = i[3];
			send_tick(t);
		end
	endtask

	task automatic test_listen();
		configure(16'd40, 16'd8, 16'd2, 8'd4);
		run_host(300, 0);
		drain();
	endtask

	task automatic test_talk();
		configure(16'd30, 16'd6, 16'd1, 8'd255);
		run_host(300, 3);
	endtask

	task automatic test_register_extremes();
		tick_t t;
		configure(16'd1, 16'd1, 16'd1, 8'd1);
		run_host(150, 5);
		configure(16'd65535, 16'd65535, 16'd3, 8'd2);
		run_host(150, 0);
		// one atn delay at a long bit delay, back to back
		configure(16'd20, 16'd5, 16'd30, 8'd3);
		no_gaps = 1;
		t = '0;
		while (m_ph != PH_ATN_COLLECT) send_tick(t);
		t.atn = 1;
		send_tick(t);
		no_gaps = 0;
	endtask

	task automatic test_random();
		configure(16'd25, 16'd7, 16'd2, 8'd6);
		run_host(500, 6);
		configure(16'd12, 16'd3, 16'd1, 8'd255);
		run_host(400, 6);
	endtask

	initial begin
		c_timeout = 16'd20000;
		c_eoi_win = 16'd400;
		c_bit_dly = 16'd160;
		c_limit = 8'd32;
		m_ph = PH_IDLE;
		m_tcnt = 0;
		m_shift = 0;
		m_bits = 0;
		m_atn[0] = 0;
		m_atn[1] = 0;
		m_atn_cnt = 0;
		m_lcnt = 0;
		m_eoi = 0;
		m_pclk = 0;
		m_pdat = 0;
		m_rd_listen = 0;
		h_byte = 0;
		h_eoi = 0;
		h_target = 2;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_field_extremes();
		test_listen();
		test_talk();
		test_register_extremes();
		test_random();
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	// receiver side: random stalls, mostly short with a few long ones
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 0;
		end else if ($urandom_range(0, 59) == 0) begin
			stall_left = $urandom_range(10, 50);
			m_tready <= 0;
		end else m_tready <= ($urandom_range(0, 4) != 0);
	end

	// output beat checker and watchdog
	always @(posedge clk) begin
		res_t e;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= 3000) begin
			$display("simulation failed");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report("unexpected beat", m_tdata[31:0], 0);
			end else begin
				e = results_due.pop_front();
				if (m_tdata[0] !== e.pull_clk) report("pull_clk", m_tdata[0], e.pull_clk);
				if (m_tdata[1] !== e.pull_data) report("pull_data", m_tdata[1], e.pull_data);
				if (m_tdata[2] !== e.ready_res) report("ready_res", m_tdata[2], e.ready_res);
				if (m_tdata[5:3] !== e.event_res)
					report("event_res", m_tdata[5:3], e.event_res);
				if (m_tdata[13:6] !== e.rx_byte) report("rx_byte", m_tdata[13:6], e.rx_byte);
				if (m_tdata[17:14] !== e.command_nibble)
					report("command_nibble", m_tdata[17:14], e.command_nibble);
				if (m_tdata[21:18] !== e.device_number)
					report("device_number", m_tdata[21:18], e.device_number);
				if (m_tdata[25:22] !== e.sec_addr)
					report("sec_addr", m_tdata[25:22], e.sec_addr);
				if (m_tdata[29:26] !== e.secondary_nibble)
					report("secondary_nibble", m_tdata[29:26], e.secondary_nibble);
				if (m_tdata[30] !== e.listen_req)
					report("listen_req", m_tdata[30], e.listen_req);
				if (m_tdata[31] !== e.talk_req) report("talk_req", m_tdata[31], e.talk_req);
			end
		end
	end
endmodule

// ===== sim.f =====
hdl/iec_pkg.sv
hdl/iec_cfg.sv
hdl/iec_core.sv
hdl/iec_serial_bus_device_engine.sv
verif/testbench.sv
